// File: rtl/core/sehm_pkg.sv
// Shared types, constants and the filter weight and update functions of the sensor health monitor.
package sehm_pkg;

    localparam int ALPHA_BITS = 10;
    localparam int ALPHA_W    = 11;
    localparam int WEIGHT_W   = ALPHA_BITS + 1;
    localparam int ALPHA_ONE  = 1 << ALPHA_BITS;

    localparam int GAS_W    = 8;
    localparam int TEMP_W   = 15;
    localparam int PRES_W   = 15;
    localparam int HEALTH_W = 7;
    localparam int LANE_W   = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 1;

    localparam logic [GAS_W-1:0]           GAS_RESET    = 8'd50;
    localparam logic signed [TEMP_W-1:0]   TEMP_RESET   = 15'sd2500;
    localparam logic [PRES_W-1:0]          PRES_RESET   = 15'd10130;
    localparam logic [HEALTH_W-1:0]        HEALTH_MAX   = 7'd100;
    localparam logic [HEALTH_W-1:0]        HEALTH_DROP  = 7'd5;
    localparam logic [ALPHA_W-1:0]         ALPHA_RESET  = 11'd717;

    localparam logic signed [LANE_W-1:0]   GAS_MAX      = 16'sd100;
    localparam logic signed [LANE_W-1:0]   TEMP_MIN     = -16'sd1000;
    localparam logic signed [LANE_W-1:0]   TEMP_MAX     = 16'sd10000;
    localparam logic signed [LANE_W-1:0]   PRES_MIN     = 16'sd9000;
    localparam logic signed [LANE_W-1:0]   PRES_MAX     = 16'sd11000;

    typedef logic signed [LANE_W-1:0] lane_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED      = 1'b0,
        REG_ALPHA_WEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                advance;
        logic                enabled;
        logic [ALPHA_W-1:0]  alpha_weight;
    } core_ctrl_t;

    typedef struct packed {
        logic [PRES_W-1:0]         raw_pressure;
        logic signed [TEMP_W-1:0]  raw_temperature;
        logic [GAS_W-1:0]          raw_gas;
    } sample_t;

    // Weight of the new sample: one minus alpha, with alpha saturated at one
    function automatic weight_t new_weight(input logic [ALPHA_W-1:0] alpha);
        weight_t w;
        if (32'(alpha) > ALPHA_ONE)
            w = '0;
        else
            w = WEIGHT_W'(ALPHA_ONE - 32'(alpha));
        return w;
    endfunction

    // old + floor(w * (raw - old) / 2^ALPHA_BITS), equal to the weighted blend
    function automatic lane_t ema_step(input lane_t old, input lane_t raw, input weight_t w);
        logic signed [LANE_W:0]            diff;
        logic signed [WEIGHT_W+LANE_W+1:0] prod;
        logic signed [WEIGHT_W+LANE_W+1:0] shifted;
        logic signed [LANE_W:0]            sum;
        diff    = (LANE_W+1)'(raw) - (LANE_W+1)'(old);
        prod    = $signed({1'b0, w}) * diff;
        shifted = prod >>> ALPHA_BITS;
        sum     = (LANE_W+1)'(old) + shifted[LANE_W:0];
        return sum[LANE_W-1:0];
    endfunction

endpackage

// File: rtl/core/sehm_core.sv
// Filter lanes, range check, health score and result register.
module sehm_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sehm_pkg::core_ctrl_t               ctrl,
    input  sehm_pkg::sample_t                  sample,
    output logic [sehm_pkg::GAS_W-1:0]         gas_level,
    output logic signed [sehm_pkg::TEMP_W-1:0] temperature,
    output logic [sehm_pkg::PRES_W-1:0]        pressure,
    output logic [sehm_pkg::HEALTH_W-1:0]      health,
    output logic                               out_of_range
);
    import sehm_pkg::*;

    logic [GAS_W-1:0]          gas_reg,    gas_next;
    logic signed [TEMP_W-1:0]  temp_reg,   temp_next;
    logic [PRES_W-1:0]         pres_reg,   pres_next;
    logic [HEALTH_W-1:0]       health_reg, health_next;
    logic                      oor_reg,    oor_next;

    weight_t w;
    lane_t   gas_new, temp_new, pres_new;
    logic    breach;

    always_comb
    begin
        w        = new_weight(ctrl.alpha_weight);
        gas_new  = ema_step(lane_t'({1'b0, 7'd0, gas_reg}),
                            lane_t'({1'b0, 7'd0, sample.raw_gas}), w);
        temp_new = ema_step(lane_t'({temp_reg[TEMP_W-1], temp_reg}),
                            lane_t'({sample.raw_temperature[TEMP_W-1],
                                     sample.raw_temperature}), w);
        pres_new = ema_step(lane_t'({1'b0, pres_reg}),
                            lane_t'({1'b0, sample.raw_pressure}), w);

        breach = (gas_new > GAS_MAX) ||
                 (temp_new < TEMP_MIN) || (temp_new > TEMP_MAX) ||
                 (pres_new < PRES_MIN) || (pres_new > PRES_MAX);

        gas_next    = gas_reg;
        temp_next   = temp_reg;
        pres_next   = pres_reg;
        health_next = health_reg;
        oor_next    = oor_reg;

        if (ctrl.advance)
        begin
            oor_next = 1'b0;
            if (ctrl.enabled)
            begin
                gas_next  = gas_new[GAS_W-1:0];
                temp_next = temp_new[TEMP_W-1:0];
                pres_next = pres_new[PRES_W-1:0];
                oor_next  = breach;
                if (breach)
                    health_next = (health_reg >= HEALTH_DROP) ? health_reg - HEALTH_DROP : '0;
                else if (health_reg < HEALTH_MAX)
                    health_next = health_reg + 7'd1;
            end
        end
    end

    // The state doubles as the result payload: results always show the state after the tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gas_reg    <= GAS_RESET;
            temp_reg   <= TEMP_RESET;
            pres_reg   <= PRES_RESET;
            health_reg <= HEALTH_MAX;
            oor_reg    <= 1'b0;
        end
        else
        begin
            gas_reg    <= gas_next;
            temp_reg   <= temp_next;
            pres_reg   <= pres_next;
            health_reg <= health_next;
            oor_reg    <= oor_next;
        end
    end

    assign gas_level    = gas_reg;
    assign temperature  = temp_reg;
    assign pressure     = pres_reg;
    assign health       = health_reg;
    assign out_of_range = oor_reg;

    a_health_cap: assert property (@(posedge clk) disable iff (!rst_n)
        health_reg <= HEALTH_MAX)
        else $error("health score above its ceiling");

    a_hold_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance && !ctrl.enabled |=>
            $stable(gas_reg) && $stable(temp_reg) && $stable(pres_reg) &&
            $stable(health_reg) && !oor_reg)
        else $error("state moved on a disabled tick");

    a_drop_on_breach: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance && ctrl.enabled |=>
            (oor_reg && (health_reg == 7'd0 ||
                         health_reg == $past(health_reg) - HEALTH_DROP)) ||
            (!oor_reg && (health_reg == $past(health_reg) + 7'd1 ||
                          health_reg == HEALTH_MAX)))
        else $error("health update does not match the range flag");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.advance |=> $stable(health_reg) && $stable(oor_reg) && $stable(gas_reg))
        else $error("result changed without a transfer");

endmodule

// File: rtl/core/sensor_ema_health_monitor.sv
// Top level: stream handshake, input register, configuration registers.
// Path: a sample passes the input register, then the result register; m_tready can stall it.
// Throughput: one sample per cycle unless m_tready stalls the output; each tick's filter update
// finishes in the result stage, so the next sample sees the updated state without a bubble.
// Reset: enabled clears, alpha_weight returns to 717, filters to 50 / 25.00 C / 101.30 kPa,
// health to 100; no result is pending.
module sensor_ema_health_monitor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [sehm_pkg::IN_TDATA_W-1:0]       s_tdata,   // raw_gas, raw_temperature, raw_pressure
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [sehm_pkg::OUT_TDATA_W-1:0]      m_tdata,   // gas_level, temperature, pressure, health
    output logic                                  m_tuser,   // out_of_range
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sehm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sehm_pkg::ALPHA_W-1:0]          cfg_data
);
    import sehm_pkg::*;

    logic                 in_valid_reg,  in_valid_next;
    sample_t              in_data_reg,   in_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 enabled_reg,   enabled_next;
    logic [ALPHA_W-1:0]   alpha_reg,     alpha_next;

    logic                 load_out;
    logic                 advance;
    logic                 in_xfer;
    core_ctrl_t           ctrl;

    logic [GAS_W-1:0]          gas_level;
    logic signed [TEMP_W-1:0]  temperature;
    logic [PRES_W-1:0]         pressure;
    logic [HEALTH_W-1:0]       health;
    logic                      out_of_range;

    assign load_out  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && load_out;
    assign s_tready  = !in_valid_reg || load_out;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        out_valid_next = out_valid_reg;
        enabled_next   = enabled_reg;
        alpha_next     = alpha_reg;

        if (advance)
            in_valid_next = 1'b0;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
            in_data_next  = sample_t'(s_tdata[GAS_W+TEMP_W+PRES_W-1:0]);
        end

        if (load_out)
            out_valid_next = in_valid_reg;

        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLED:      enabled_next = cfg_data[0];
                REG_ALPHA_WEIGHT: alpha_next   = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enabled_reg   <= 1'b0;
            alpha_reg     <= ALPHA_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            enabled_reg   <= enabled_next;
            alpha_reg     <= alpha_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    assign ctrl.advance      = advance;
    assign ctrl.enabled      = enabled_reg;
    assign ctrl.alpha_weight = alpha_reg;

    sehm_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .sample       (in_data_reg),
        .gas_level    (gas_level),
        .temperature  (temperature),
        .pressure     (pressure),
        .health       (health),
        .out_of_range (out_of_range)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, health, pressure, temperature, gas_level};
    assign m_tuser  = out_of_range;

endmodule
